// File: rtl/trlp_pkg.sv
package trlp_pkg;

   localparam int COMMAND_CHARS = 8;
   localparam int PEND_MAX      = 16;
   localparam int PEND_W        = $clog2(PEND_MAX + 1);
   localparam int PIDX_W        = (PEND_MAX > 1) ? $clog2(PEND_MAX) : 1;
   localparam int CPOS_W        = $clog2(COMMAND_CHARS);

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_E   = 8'h45;
   localparam logic [7:0] CH_W   = 8'h57;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [23:0] SYS_TEXT = 24'h535953;

   localparam logic [0:0] CSR_EXP_CMD = 1'b0;
   localparam logic [0:0] CSR_EXP_LEN = 1'b1;

   localparam logic [1:0] KIND_INVALID = 2'd0;
   localparam logic [1:0] KIND_NORMAL  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_WARNING = 2'd3;

   localparam logic [1:0] NS_WS     = 2'd0;
   localparam logic [1:0] NS_SIGN   = 2'd1;
   localparam logic [1:0] NS_DIGITS = 2'd2;
   localparam logic [1:0] NS_BAD    = 2'd3;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        system_event;
      logic [63:0] command_text;
      logic [7:0]  command_length;
      logic [7:0]  field_count;
      logic        code_valid;
      logic signed [31:0] code;
      logic        command_matches;
   } rsp_type;

   // one character handed from front to back
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       ovf;
   } op_type;

endpackage

// File: rtl/trlp_front.sv
module trlp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trlp_pkg::req_type req_data,
   output logic              op_valid,
   input  logic              op_full,
   output trlp_pkg::op_type  op_data
);
   logic [trlp_pkg::PEND_MAX-1:0] brk_ff, brk_in;
   logic [trlp_pkg::PEND_W-1:0]   cnt_ff, cnt_in;
   logic [trlp_pkg::PEND_W-1:0]   rp_ff, rp_in;
   logic                          ovf_ff, ovf_in;
   logic                          is_brk, replaying;

   assign is_brk    = (req_data.line_byte == trlp_pkg::CH_CR) ||
                      (req_data.line_byte == trlp_pkg::CH_LF);
   // held breaks replay one per cycle, queue permitting, ahead of the next plain byte
   assign replaying = req_valid && !is_brk && (rp_ff != cnt_ff);
   assign req_stall = op_full || replaying;

   always_comb begin
      brk_in   = brk_ff;
      cnt_in   = cnt_ff;
      rp_in    = rp_ff;
      ovf_in   = ovf_ff;
      op_valid = 1'b0;
      op_data  = '0;
      if (!op_full && req_valid) begin
         if (replaying) begin
            op_valid   = 1'b1;
            op_data.ch = brk_ff[rp_ff[trlp_pkg::PIDX_W-1:0]] ?
                         trlp_pkg::CH_LF : trlp_pkg::CH_CR;
            rp_in = rp_ff + 1'b1;
         end else if (is_brk) begin
            if (cnt_ff >= trlp_pkg::PEND_W'(trlp_pkg::PEND_MAX)) begin
               ovf_in = 1'b1;
            end else begin
               brk_in[cnt_ff[trlp_pkg::PIDX_W-1:0]] =
                  (req_data.line_byte == trlp_pkg::CH_LF);
               cnt_in = cnt_ff + 1'b1;
            end
            if (req_data.line_end) begin
               op_valid    = 1'b1;
               op_data.ch  = trlp_pkg::CH_CR;
               op_data.fin = 1'b1;
               op_data.ovf = ovf_in;
               op_data.ch  = 8'h00;
            end
         end else begin
            op_valid    = 1'b1;
            op_data.ch  = req_data.line_byte;
            cnt_in      = '0;
            rp_in       = '0;
            op_data.fin = req_data.line_end;
            op_data.ovf = ovf_ff;
         end
         if (req_data.line_end && !replaying) begin
            cnt_in = '0;
            rp_in  = '0;
            ovf_in = 1'b0;
         end
      end
   end

   // a break byte with the end mark carries no character: flagged by ch zero plus brk
   always_ff @(posedge clock) begin
      brk_ff <= brk_in;
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         ovf_ff <= ovf_in;
      end
   end

   nobrk_overflow_a: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= trlp_pkg::PEND_W'(trlp_pkg::PEND_MAX))
      else $error("break count beyond store");
   rp_bound_a: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= cnt_ff)
      else $error("replay pointer past count");
   replay_stall_a: assert property (@(posedge clock) disable iff (reset)
      replaying |-> req_stall)
      else $error("byte taken during replay");
endmodule

// File: rtl/trlp_queue.sv
module trlp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_brk,
   input  trlp_pkg::op_type in_data,
   output logic             full,
   output logic             out_valid,
   output logic             out_brk,
   input  logic             out_take,
   output trlp_pkg::op_type out_data
);
   trlp_pkg::op_type  mem_ff [2];
   logic [1:0]        brk_ff;
   logic [1:0]        wp_ff, rp_ff;
   logic              wr, rd;

   assign full      = (wp_ff - rp_ff) == 2'd2;
   assign out_valid = wp_ff != rp_ff;
   assign out_data  = mem_ff[rp_ff[0]];
   assign out_brk   = brk_ff[rp_ff[0]];
   assign wr        = in_valid && !full;
   assign rd        = out_valid && out_take;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff[0]] <= in_data;
         brk_ff[wp_ff[0]] <= in_brk;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
      end
   end

   level_a: assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= 2'd2) else $error("queue level out of range");
endmodule

// File: rtl/trlp_back.sv
module trlp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       exp_cmd,
   input  logic [3:0]        exp_len,
   input  logic              op_valid,
   input  logic              op_brk,
   input  trlp_pkg::op_type  op_data,
   output logic              op_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trlp_pkg::rsp_type rsp_data
);
   logic [1:0]  ph_ff;
   logic [7:0]  ftc_ff;
   logic [1:0]  ftl_ff;
   logic [63:0] cbuf_ff;
   logic [7:0]  ccnt_ff;
   logic        pre_ff, suf_ff, sys_ff;
   logic [7:0]  fld_ff;
   logic [63:0] acc_ff;
   logic [1:0]  nph_ff;
   logic        neg_ff, novf_ff;
   logic        rv_ff;
   trlp_pkg::rsp_type rsp_ff;

   logic [7:0]  c;
   logic [3:0]  el;
   logic        dig, ws, go;
   logic [63:0] lim, acc10;
   logic [67:0] prod;
   logic [1:0]  ph_n, ftl_n;
   logic [7:0]  ftc_n, ccnt_n, fld_n;
   logic [63:0] cbuf_n, acc_n;
   logic        pre_n, suf_n, sys_n, neg_n, novf_n;
   logic [1:0]  nph_n;
   logic [1:0]  kd;
   logic        sy;
   logic [63:0] v;
   trlp_pkg::rsp_type r;

   assign c    = op_data.ch;
   assign el   = (exp_len > 4'd8) ? 4'd8 : exp_len;
   assign dig  = (c >= trlp_pkg::CH_0) && (c <= trlp_pkg::CH_9);
   assign ws   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   assign go   = op_valid && !(rv_ff && rsp_stall);
   assign op_take = go;
   assign lim  = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
   assign prod = {4'd0, acc_ff} * 68'd10 + 68'(c - trlp_pkg::CH_0);
   assign acc10 = prod[63:0];

   always_comb begin
      ph_n = ph_ff; ftc_n = ftc_ff; ftl_n = ftl_ff; cbuf_n = cbuf_ff;
      ccnt_n = ccnt_ff; pre_n = pre_ff; suf_n = suf_ff; sys_n = sys_ff;
      fld_n = fld_ff; acc_n = acc_ff; nph_n = nph_ff; neg_n = neg_ff;
      novf_n = novf_ff;
      if (!op_brk) begin
         if (ph_ff == 2'd0) begin
            if (c == trlp_pkg::CH_TAB) ph_n = 2'd1;
            else begin
               if (ftl_ff == 2'd0) ftc_n = c;
               if (ftl_ff != 2'd2) ftl_n = ftl_ff + 2'd1;
            end
         end else if (ph_ff == 2'd1) begin
            if (c == trlp_pkg::CH_TAB) begin
               ph_n = 2'd2; fld_n = 8'd1;
               acc_n = '0; nph_n = trlp_pkg::NS_WS; neg_n = 1'b0; novf_n = 1'b0;
            end else begin
               if (ccnt_ff < 8'(trlp_pkg::COMMAND_CHARS))
                  cbuf_n[8*ccnt_ff[trlp_pkg::CPOS_W-1:0] +: 8] = c;
               if (ccnt_ff < {4'd0, el}) begin
                  if (exp_cmd[8*ccnt_ff[2:0] +: 8] != c) pre_n = 1'b0;
               end else if (!dig) suf_n = 1'b0;
               if (ccnt_ff < 8'd3) begin
                  if (trlp_pkg::SYS_TEXT[8*(2-ccnt_ff[1:0]) +: 8] != c) sys_n = 1'b0;
               end else sys_n = 1'b0;
               if (ccnt_ff != 8'd255) ccnt_n = ccnt_ff + 8'd1;
            end
         end else begin
            if (c == trlp_pkg::CH_TAB) begin
               if (fld_ff != 8'd255) fld_n = fld_ff + 8'd1;
               acc_n = '0; nph_n = trlp_pkg::NS_WS; neg_n = 1'b0; novf_n = 1'b0;
            end else if (nph_ff == trlp_pkg::NS_BAD) begin
            end else if (nph_ff == trlp_pkg::NS_WS && ws) begin
            end else if (nph_ff == trlp_pkg::NS_WS && (c == 8'h2b || c == 8'h2d)) begin
               nph_n = trlp_pkg::NS_SIGN; neg_n = (c == 8'h2d);
            end else if (!dig) nph_n = trlp_pkg::NS_BAD;
            else begin
               nph_n = trlp_pkg::NS_DIGITS;
               if (!novf_ff) begin
                  if (prod[67:64] != 4'd0 || acc10 > lim) novf_n = 1'b1;
                  else acc_n = acc10;
               end
            end
         end
      end
      kd = trlp_pkg::KIND_INVALID;
      if (ph_n != 2'd0 && ftl_n == 2'd1 && !op_data.ovf) begin
         unique case (ftc_n)
            trlp_pkg::CH_C: kd = trlp_pkg::KIND_NORMAL;
            trlp_pkg::CH_E: kd = trlp_pkg::KIND_ERROR;
            trlp_pkg::CH_W: kd = trlp_pkg::KIND_WARNING;
            default:        kd = trlp_pkg::KIND_INVALID;
         endcase
      end
      sy = sys_n && ccnt_n == 8'd3;
      v  = neg_n ? (64'd0 - acc_n) : acc_n;
      r  = '0;
      if (kd != trlp_pkg::KIND_INVALID) begin
         r.kind = kd; r.system_event = sy; r.command_text = cbuf_n;
         r.command_length = ccnt_n; r.field_count = fld_n;
         if (kd[1] && fld_n != 8'd0 && nph_n == trlp_pkg::NS_DIGITS && !novf_n) begin
            r.code_valid = 1'b1; r.code = v[31:0];
         end
         r.command_matches = el != 4'd0 && !sy && pre_n && ccnt_n >= {4'd0, el} && suf_n;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (go && op_data.fin) rsp_ff <= r;
      if (reset || (go && op_data.fin)) begin
         ph_ff <= '0; ftc_ff <= '0; ftl_ff <= '0; cbuf_ff <= '0; ccnt_ff <= '0;
         pre_ff <= 1'b1; suf_ff <= 1'b1; sys_ff <= 1'b1; fld_ff <= '0;
         acc_ff <= '0; nph_ff <= trlp_pkg::NS_WS; neg_ff <= 1'b0; novf_ff <= 1'b0;
      end else if (go) begin
         ph_ff <= ph_n; ftc_ff <= ftc_n; ftl_ff <= ftl_n; cbuf_ff <= cbuf_n;
         ccnt_ff <= ccnt_n; pre_ff <= pre_n; suf_ff <= suf_n; sys_ff <= sys_n;
         fld_ff <= fld_n; acc_ff <= acc_n; nph_ff <= nph_n; neg_ff <= neg_n;
         novf_ff <= novf_n;
      end
      if (reset) rv_ff <= 1'b0;
      else if (go && op_data.fin) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
   end

   invalid_zero_a: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.kind == trlp_pkg::KIND_INVALID |-> rsp_ff.field_count == 8'd0)
      else $error("invalid line with fields");
   code_kind_a: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.code_valid |-> rsp_ff.kind[1])
      else $error("code on normal line");
   hold_a: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff)
      else $error("result dropped under stall");
endmodule

// File: rtl/tab_response_line_parser.sv
// tab response line parser
// req_ channel: one line byte per transaction, line_end on the final byte.
// rsp_ channel: one result transaction per line, issued after the final byte.
// csr_ channel: index 0 expected command, index 1 expected length; write
//   only while no line is in flight.
// throughput: one byte per cycle while the queue is not full. cr/lf bytes
//   are held in a 16-entry flag store; when a plain byte follows a held
//   run, each held byte is replayed through the front end one per cycle,
//   and that byte waits until the held breaks are replayed. the result
//   passes through the two-entry queue and the back end output register.
// the back end parses one character per cycle unless its result is stalled;
//   its decimal multiply-by-ten and range compare sit on that single step.
// reset clears the line state, the queue and the result valid flag; the
//   expected command and length registers return to zero.
// when rsp_stall is high with a result pending, the result is held; the queue
//   fills and req_stall rises while the line state stays put.
module tab_response_line_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trlp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [63:0]       csr_data
);
   logic [63:0] exp_cmd_ff;
   logic [3:0]  exp_len_ff;
   logic        f_valid, q_full, q_valid, q_brk, q_take, f_brk;
   trlp_pkg::op_type f_data, q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff <= '0;
         exp_len_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            trlp_pkg::CSR_EXP_CMD: exp_cmd_ff <= csr_data;
            trlp_pkg::CSR_EXP_LEN: exp_len_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // a trailing break carrying the end mark is sent as a no-character marker
   assign f_brk = ((req_data.line_byte == trlp_pkg::CH_CR) ||
                   (req_data.line_byte == trlp_pkg::CH_LF)) && f_data.fin;

   trlp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .op_valid(f_valid), .op_full(q_full), .op_data(f_data));

   trlp_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_brk(f_brk), .in_data(f_data),
      .full(q_full), .out_valid(q_valid), .out_brk(q_brk), .out_take(q_take),
      .out_data(q_data));

   trlp_back u_back (
      .clock, .reset, .exp_cmd(exp_cmd_ff), .exp_len(exp_len_ff),
      .op_valid(q_valid), .op_brk(q_brk), .op_data(q_data), .op_take(q_take),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule
